/* hdl/nkc_pkg.sv */
// ----------------------------------------------------------------------------
// nkc_pkg
// Shared types and constants for the N-of-K membership counter.
// ----------------------------------------------------------------------------
package nkc_pkg;

    localparam int ID_W        = 16;
    localparam int THRESH_W    = 8;
    localparam int LIMIT_W     = 17;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_COUNT  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_EXACT_MODE = 2'd1;
    localparam logic [1:0] REG_ID_LIMIT   = 2'd2;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST = 8'd1;
    localparam logic [LIMIT_W-1:0]  ID_LIMIT_RST  = 17'h10000;

    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] id;
        logic            hit;
    } item_t;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic                exact_mode;
        logic [LIMIT_W-1:0]  id_limit;
    } cfg_t;

    typedef struct packed {
        logic clearing;
    } stat_t;

endpackage

/* hdl/nkc_ram.sv */
// ----------------------------------------------------------------------------
// nkc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/nkc_queue.sv */
// ----------------------------------------------------------------------------
// nkc_queue
// Short item queue between the classifying front and the counter back end.
// ----------------------------------------------------------------------------
module nkc_queue
    import nkc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head_item,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hdl/nkc_front.sv */
// ----------------------------------------------------------------------------
// nkc_front
// Configuration registers, input handshake and id range classification.
// ----------------------------------------------------------------------------
module nkc_front
    import nkc_pkg::*;
#(
    parameter int ID_SPACE = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [ID_W-1:0]       member_id,
    input  logic                  q_full,
    input  stat_t                 stat,
    output logic                  push,
    output item_t                 push_item,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg, cfg_next;
    logic [1:0] reg_index;
    logic       wr_fire;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign wr_fire   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_fire)
        begin
            case (reg_index)
                REG_THRESHOLD:  cfg_next.threshold  = pwdata[THRESH_W-1:0];
                REG_EXACT_MODE: cfg_next.exact_mode = pwdata[0];
                REG_ID_LIMIT:   cfg_next.id_limit   = pwdata[LIMIT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_THRESHOLD:  prdata = APB_DATA_W'(cfg_reg.threshold);
            REG_EXACT_MODE: prdata = APB_DATA_W'(cfg_reg.exact_mode);
            REG_ID_LIMIT:   prdata = APB_DATA_W'(cfg_reg.id_limit);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= THRESHOLD_RST;
            cfg_reg.exact_mode <= 1'b0;
            cfg_reg.id_limit   <= ID_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // id is counted only below both the programmed limit and the id space
    assign in_stall      = q_full || stat.clearing;
    assign push          = in_valid && !in_stall;
    assign push_item.op  = operation;
    assign push_item.id  = member_id;
    assign push_item.hit = (32'(member_id) < 32'(cfg_reg.id_limit))
                        && (32'(member_id) < 32'(ID_SPACE));
    assign cfg           = cfg_reg;

endmodule

/* hdl/nkc_back.sv */
// ----------------------------------------------------------------------------
// nkc_back
// Counter store sequencer: clearing pass, read-modify-write, result register.
// ----------------------------------------------------------------------------
module nkc_back
    import nkc_pkg::*;
#(
    parameter int ID_SPACE      = 65536,
    parameter int MAX_THRESHOLD = 255
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  item_t           head_item,
    input  logic            q_empty,
    output logic            pop,
    output stat_t           stat,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [ID_W-1:0] result_id,
    output logic            selected
);

    localparam int MEM_DEPTH = (ID_SPACE > (1 << ID_W)) ? (1 << ID_W) : ID_SPACE;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(MAX_THRESHOLD + 2);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              cur_op_reg, cur_op_next;
    logic [ID_W-1:0]   cur_id_reg, cur_id_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   result_id_reg, result_id_next;
    logic              selected_reg, selected_next;

    logic              out_free;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
    logic [CNT_W-1:0]  rd_data;
    logic [31:0]       eff_t_wide;
    logic [CNT_W-1:0]  eff_t;
    logic              sel_hit;

    assign eff_t_wide = (32'(cfg.threshold) > 32'(MAX_THRESHOLD))
                      ? 32'(MAX_THRESHOLD) : 32'(cfg.threshold);
    assign eff_t      = eff_t_wide[CNT_W-1:0];
    assign sel_hit    = cfg.exact_mode ? (rd_data == eff_t) : (rd_data >= eff_t);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cur_op_next    = cur_op_reg;
        cur_id_next    = cur_id_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_id_next = result_id_reg;
        selected_next  = selected_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cur_id_reg[ADDR_W-1:0];
        wr_data        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    pop         = 1'b1;
                    cur_op_next = head_item.op;
                    cur_id_next = head_item.id;
                    if (head_item.hit)
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_READ;
                    end
                    else if (head_item.op == OP_REPORT)
                    begin
                        out_valid_next = 1'b1;
                        result_id_next = head_item.id;
                        selected_next  = 1'b0;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
                if (cur_op_reg == OP_COUNT)
                begin
                    // saturate one above the threshold
                    wr_en   = (rd_data <= eff_t);
                    wr_data = CNT_W'(rd_data + 1'b1);
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_data        = '0;
                    out_valid_next = 1'b1;
                    result_id_next = cur_id_reg;
                    selected_next  = sel_hit;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_op_reg    <= cur_op_next;
        cur_id_reg    <= cur_id_next;
        result_id_reg <= result_id_next;
        selected_reg  <= selected_next;
    end

    nkc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MEM_DEPTH)
    ) u_counts (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_item.id[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign stat.clearing = (state_reg == ST_CLEAR);
    assign out_valid     = out_valid_reg;
    assign result_id     = result_id_reg;
    assign selected      = selected_reg;

endmodule

/* hdl/n_of_k_membership_counter_core.sv */
// ----------------------------------------------------------------------------
// n_of_k_membership_counter_core
// Per-id hit counting with N-of threshold or exact-match reporting.
// ----------------------------------------------------------------------------
// After reset the block sweeps the counter memory to zero, one entry per
// cycle, and holds in_stall high until done; configuration writes are
// taken throughout. Items then enter a two-entry queue at up to one per
// cycle while the queue is not full. For each id inside the limit the back
// end reads the single counter memory, then writes it back, and it passes an
// id outside the limit with no memory access; it pops no new item until the
// write back is done, and only while the result register is free.
// A report inside the limit raises out_valid in the cycle after it leaves
// the queue, and a report outside it raises out_valid on the edge that
// pops it; counts give no result.
module n_of_k_membership_counter_core
    import nkc_pkg::*;
#(
    parameter int ID_SPACE      = 65536,
    parameter int MAX_THRESHOLD = 255
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [ID_W-1:0]       member_id,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ID_W-1:0]       result_id,
    output logic                  selected
);

    cfg_t  cfg;
    stat_t stat;
    item_t push_item;
    item_t head_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    nkc_front #(
        .ID_SPACE (ID_SPACE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .member_id (member_id),
        .q_full    (q_full),
        .stat      (stat),
        .push      (push),
        .push_item (push_item),
        .cfg       (cfg)
    );

    nkc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    nkc_back #(
        .ID_SPACE      (ID_SPACE),
        .MAX_THRESHOLD (MAX_THRESHOLD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head_item (head_item),
        .q_empty   (q_empty),
        .pop       (pop),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_id (result_id),
        .selected  (selected)
    );

endmodule

/* hdl/nkc_checker.sv */
// ----------------------------------------------------------------------------
// nkc_checker
// Port-level checks for the membership counter, bound to the top level.
// ----------------------------------------------------------------------------
module nkc_checker
    import nkc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  operation,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [ID_W-1:0]       result_id,
    input logic                  selected
);

    logic [3:0] pend_reg, pend_next;
    logic       rpt_in;
    logic       res_out;

    assign rpt_in  = in_valid && !in_stall && (operation == OP_REPORT);
    assign res_out = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (rpt_in && !res_out)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (res_out && !rpt_in)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // memory clearing keeps the input stalled right after reset
    a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
        else $error("input not stalled during clearing pass");

    // every result belongs to a report accepted earlier
    a_result_has_report: assert property (@(posedge clk) disable iff (!rst_n)
        res_out |-> (pend_reg != '0))
        else $error("result without pending report");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_id) && $stable(selected))
        else $error("stalled result changed");

endmodule

bind n_of_k_membership_counter_core nkc_checker u_nkc_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the N-of-K membership counter core.
// Streams count and report items through the valid/stall ports with random
// gaps on both sides and one long output hold. Between phases it rewrites
// threshold, exact mode and id limit over APB. Every reported id and select flag
// is checked in order against an in-bench per-id hit counter model or a directed flag.
// ----------------------------------------------------------------------------
module tb;
    import nkc_pkg::*;

    localparam int ID_SPACE      = 65536;
    localparam int MAX_THRESHOLD = 255;
    localparam int IDLE_MAX      = 11;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_AT       = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int N_PLAN        = 27;
    localparam int N_PHASES      = 8;
    localparam int SAT_ID        = 4242;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            sel;
    } report_t;

    typedef struct packed {
        logic            is_wr;
        logic [1:0]      reg_idx;
        logic [31:0]     value;
        logic            op;
        logic [ID_W-1:0] id;
        logic            typed;
        logic            sel;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic                  operation;
    logic [ID_W-1:0]       member_id;
    logic                  out_valid;
    logic                  out_stall;
    logic [ID_W-1:0]       result_id;
    logic                  selected;

    // model state
    bit   [8:0]            tally [ID_SPACE];
    logic [THRESH_W-1:0]   cur_threshold;
    logic                  cur_exact;
    logic [LIMIT_W-1:0]    cur_limit;

    report_t               due_reports [$];
    int                    fails        = 0;
    int                    n_items      = 0;
    int                    n_reports    = 0;
    int                    n_writes     = 0;
    int                    results_seen = 0;
    int                    cycle_count  = 0;
    bit                    src_calm     = 1'b0;

    always #5 clk = ~clk;

    n_of_k_membership_counter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .member_id (member_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_id (result_id),
        .selected  (selected)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports still due",
                     cycle_count, due_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // updates the hit counters and returns the select flag of a report
    function automatic logic apply_membership(logic op, logic [ID_W-1:0] id);
        int unsigned lim;
        int unsigned thr;
        logic        hit;
        lim = (cur_limit > ID_SPACE) ? ID_SPACE : cur_limit;
        thr = (cur_threshold > MAX_THRESHOLD) ? MAX_THRESHOLD : cur_threshold;
        hit = 1'b0;
        if (id < lim)
        begin
            if (op == OP_COUNT)
            begin
                if (tally[id] < thr + 1)
                    tally[id] = tally[id] + 9'd1;
            end
            else
            begin
                hit = cur_exact ? (tally[id] == thr) : (tally[id] >= thr);
                tally[id] = '0;
            end
        end
        return hit;
    endfunction

    function automatic step_t count_row(logic [ID_W-1:0] id);
        return step_t'{1'b0, 2'd0, 32'd0, OP_COUNT, id, 1'b0, 1'b0};
    endfunction

    function automatic step_t report_row(logic [ID_W-1:0] id);
        return step_t'{1'b0, 2'd0, 32'd0, OP_REPORT, id, 1'b0, 1'b0};
    endfunction

    function automatic step_t known_row(logic [ID_W-1:0] id, logic sel);
        return step_t'{1'b0, 2'd0, 32'd0, OP_REPORT, id, 1'b1, sel};
    endfunction

    function automatic step_t write_row(logic [1:0] idx, logic [31:0] value);
        return step_t'{1'b1, idx, value, OP_COUNT, 16'd0, 1'b0, 1'b0};
    endfunction

    task automatic note_fail(string msg);
        fails++;
        if (fails <= 10)
            $display("%s", msg);
    endtask

    task automatic send_item(logic op, logic [ID_W-1:0] id, logic typed, logic typed_sel);
        int      gap;
        logic    hit;
        report_t rep;
        if ($urandom_range(0, 29) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        member_id <= id;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        hit = apply_membership(op, id);
        n_items++;
        if (op == OP_REPORT)
        begin
            n_reports++;
            rep.id  = id;
            rep.sel = typed ? typed_sel : hit;
            due_reports = {due_reports, rep};
        end
    endtask

    // counts leave no result, so let the pipeline settle after the last report
    task automatic quiesce();
        in_valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [31:0] value);
        quiesce();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_THRESHOLD:  cur_threshold = value[THRESH_W-1:0];
            REG_EXACT_MODE: cur_exact     = value[0];
            REG_ID_LIMIT:   cur_limit     = value[LIMIT_W-1:0];
            default:        ;
        endcase
        n_writes++;
    endtask

    initial
    begin : sink
        report_t want;
        int      stall_left;
        int      hold_left;
        bit      calm;
        bit      held;
        stall_left = 0;
        hold_left  = 0;
        calm       = 1'b0;
        held       = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                results_seen++;
                if (due_reports.size() == 0)
                    note_fail($sformatf("unexpected result: id %h selected %b",
                                        result_id, selected));
                else
                begin
                    want = due_reports.pop_front();
                    if (result_id !== want.id || selected !== want.sel)
                        note_fail($sformatf(
                            "result %0d: id exp %h got %h, selected exp %b got %b",
                            results_seen, want.id, result_id, want.sel, selected));
                end
                if ($urandom_range(0, 24) == 0)
                    calm = !calm;
                stall_left = calm ? 0 : $urandom_range(0, IDLE_MAX);
            end
            // long hold while the source is mid-stream
            if (!held && n_items >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        step_t           plan [N_PLAN];
        int              ph_thr   [N_PHASES];
        int              ph_exact [N_PHASES];
        int              ph_limit [N_PHASES];
        int              ph_items [N_PHASES];
        logic [ID_W-1:0] pool [8];
        int              lim;
        int              rpt_pct;
        logic            op;
        logic [ID_W-1:0] id;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        operation <= OP_COUNT;
        member_id <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cur_threshold = THRESHOLD_RST;
        cur_exact     = 1'b0;
        cur_limit     = ID_LIMIT_RST;
        plan = '{
            known_row(16'd0, 1'b0),
            count_row(16'd0),
            known_row(16'd0, 1'b1),
            known_row(16'd0, 1'b0),
            count_row(16'hFFFF),
            count_row(16'hFFFF),
            count_row(16'hFFFF),
            known_row(16'hFFFF, 1'b1),
            write_row(REG_THRESHOLD, 32'd2),
            write_row(REG_EXACT_MODE, 32'd1),
            count_row(16'd7),
            count_row(16'd7),
            known_row(16'd7, 1'b1),
            count_row(16'd9),
            count_row(16'd9),
            count_row(16'd9),
            report_row(16'd9),
            write_row(REG_ID_LIMIT, 32'd100),
            count_row(16'd100),
            known_row(16'd100, 1'b0),
            count_row(16'd99),
            write_row(REG_THRESHOLD, 32'd0),
            report_row(16'd99),
            known_row(16'd98, 1'b1),
            write_row(REG_ID_LIMIT, 32'd131071),
            write_row(REG_EXACT_MODE, 32'd0),
            report_row(16'd100)
        };
        ph_thr   = '{1, 3, 1, 255, 0, 0, 2, 4};
        ph_exact = '{0, 1, 0, 0, 0, 1, 1, 0};
        ph_limit = '{65536, 1000, 1000, 65537, 0, 65535, 5, 131071};
        ph_items = '{40, 40, 30, 20, 20, 30, 40, 50};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_wr)
                set_reg(plan[i].reg_idx, plan[i].value);
            else
                send_item(plan[i].op, plan[i].id, plan[i].typed, plan[i].sel);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_reg(REG_THRESHOLD, ph_thr[p]);
            set_reg(REG_EXACT_MODE, ph_exact[p]);
            set_reg(REG_ID_LIMIT, ph_limit[p]);
            lim = (ph_limit[p] > ID_SPACE) ? ID_SPACE : ph_limit[p];
            pool[0] = 16'd0;
            pool[1] = 16'hFFFF;
            pool[2] = ID_W'((lim > 0) ? lim - 1 : 0);
            pool[3] = (lim < ID_SPACE) ? ID_W'(lim) : 16'hFFFE;
            for (int k = 4; k < 8; k++)
                pool[k] = ID_W'((lim > 0) ? $urandom_range(0, lim - 1)
                                          : $urandom_range(0, 65535));
            rpt_pct = (ph_thr[p] <= 1) ? 40 : ((ph_thr[p] >= 100) ? 8 : 25);
            // saturation at the top threshold
            if (ph_thr[p] == MAX_THRESHOLD)
            begin
                for (int c = 0; c < MAX_THRESHOLD + 2; c++)
                    send_item(OP_COUNT, ID_W'(SAT_ID), 1'b0, 1'b0);
                send_item(OP_REPORT, ID_W'(SAT_ID), 1'b0, 1'b0);
            end
            for (int n = 0; n < ph_items[p]; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    op = 1'($urandom_range(0, 1));
                    id = ID_W'($urandom_range(0, 65535));
                end
                else
                begin
                    op = ($urandom_range(0, 99) < rpt_pct) ? OP_REPORT : OP_COUNT;
                    id = pool[3'($urandom_range(0, 7))];
                end
                send_item(op, id, 1'b0, 1'b0);
            end
        end

        quiesce();
        $display("covered %0d items, %0d reports, %0d results, %0d register writes",
                 n_items, n_reports, results_seen, n_writes);
        $display("thresholds 0 to 255, both modes, id limits 0 to 131071, one long output hold");
        if (fails == 0 && due_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
hdl/nkc_pkg.sv
hdl/nkc_ram.sv
hdl/nkc_queue.sv
hdl/nkc_front.sv
hdl/nkc_back.sv
hdl/n_of_k_membership_counter_core.sv
hdl/nkc_checker.sv
dv/tb.sv
